// ===== hw/rtl/golge_pkg.sv =====
// Shared constants for the cellular automaton grid engine.
// Holds operation codes, field widths, rule counts and default grid sizes.
// No dependencies.
`default_nettype none

package golge_pkg;

    localparam int DEF_GRID_WIDTH  = 160;
    localparam int DEF_GRID_HEIGHT = 100;

    localparam int FUNC_W = 2;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int CNT_W  = 4;

    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd2;

    localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [CNT_W-1:0] KEEP_COUNT  = 4'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/game_of_life_grid_engine.sv =====
// Top level of the B3/S23 cellular automaton grid engine.
// Depends on golge_pkg for operation codes, widths and rule counts.
//
// Usage: one item on the slave channel carries an operation in tuser (read cell,
// toggle cell, advance one generation) and a column and row in tdata. Every item
// gives exactly one result item on the master channel: the echoed operation in
// tuser, the cell state and an out-of-range flag in tdata.
// The grid lives in a row-wide memory of GRID_HEIGHT words; a valid flag per row,
// cleared at reset, makes unwritten rows read as dead, so no clearing pass runs.
// A read or toggle goes from acceptance to a result through one memory read,
// one update step and the loading of the output register.
// A generation step sweeps the grid row by row through three row buffers and a
// single neighbor count and rule unit that handles one column per cycle.
// Unused operation codes and out-of-range coordinates skip memory and update.
// The slave side is ready whenever no item is in work, also while a result still
// waits in the output register. If the receiver stalls, the next item finishes its
// work and then holds until the output register is free.
// Synchronous active-low reset empties the grid and drops any pending result.
`default_nettype none

module game_of_life_grid_engine #(
    parameter int GRID_WIDTH  = golge_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = golge_pkg::DEF_GRID_HEIGHT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: col [7:0], row [14:8], zero [15]
    input  wire logic [15:0] i_s_axis_tdata,
    // tuser: func [1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: cell_alive [0], out_of_range [1], zero [7:2]
    output logic [7:0]       o_m_axis_tdata,
    // tuser: kind [1:0]
    output logic [1:0]       o_m_axis_tuser
);

    localparam int CW = $clog2(GRID_WIDTH);
    localparam int RW = $clog2(GRID_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL,
        S_FIN,
        S_ST_L0,
        S_ST_L1,
        S_ST_L2,
        S_ST_COL,
        S_ST_WR,
        S_ST_NXT,
        S_ST_LAST
    } t_state;

    t_state r_state;

    logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] r_rd_data;
    logic                  r_rd_ok;
    logic [GRID_HEIGHT-1:0] r_row_valid;

    logic [GRID_WIDTH-1:0] r_above;
    logic [GRID_WIDTH-1:0] r_mid;
    logic [GRID_WIDTH-1:0] r_below;
    logic [GRID_WIDTH-1:0] r_nrow;

    logic [CW-1:0]                r_col;
    logic [RW-1:0]                r_row;
    logic [golge_pkg::FUNC_W-1:0] r_func;

    logic [golge_pkg::FUNC_W-1:0] r_res_kind;
    logic                         r_res_alive;
    logic                         r_res_oor;

    logic                         r_out_valid;
    logic [golge_pkg::FUNC_W-1:0] r_out_kind;
    logic                         r_out_alive;
    logic                         r_out_oor;

    logic [golge_pkg::FUNC_W-1:0] w_in_func;
    logic [golge_pkg::COL_W-1:0]  w_in_col;
    logic [golge_pkg::ROW_W-1:0]  w_in_row;
    logic                         w_in_oor;
    logic                         w_accept;

    logic                  w_rd_en;
    logic [RW-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [RW-1:0]         w_wr_addr;
    logic [GRID_WIDTH-1:0] w_wr_data;
    logic [GRID_WIDTH-1:0] w_rd_row;

    logic                  w_cell_bit;
    logic                  w_cell_new;
    logic [CW-1:0]         w_cm;
    logic [CW-1:0]         w_cp;
    logic [golge_pkg::CNT_W-1:0] w_cnt;
    logic                  w_next_alive;

    assign w_in_func = i_s_axis_tuser;
    assign w_in_col  = i_s_axis_tdata[7:0];
    assign w_in_row  = i_s_axis_tdata[14:8];
    assign w_in_oor  = ({1'b0, w_in_col} >= 9'(GRID_WIDTH))
                    || ({1'b0, w_in_row} >= 8'(GRID_HEIGHT));
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_oor, r_out_alive};
    assign o_m_axis_tuser  = r_out_kind;

    assign w_rd_row   = r_rd_ok ? r_rd_data : '0;
    assign w_cell_bit = w_rd_row[r_col];
    assign w_cell_new = (r_func == golge_pkg::FUNC_TOGGLE) ? ~w_cell_bit : w_cell_bit;

    // Shared neighbor count and rule unit, one column per cycle.
    assign w_cm  = r_col - CW'(1);
    assign w_cp  = r_col + CW'(1);
    assign w_cnt = golge_pkg::CNT_W'(r_above[w_cm]) + golge_pkg::CNT_W'(r_above[r_col])
                 + golge_pkg::CNT_W'(r_above[w_cp]) + golge_pkg::CNT_W'(r_mid[w_cm])
                 + golge_pkg::CNT_W'(r_mid[w_cp])   + golge_pkg::CNT_W'(r_below[w_cm])
                 + golge_pkg::CNT_W'(r_below[r_col]) + golge_pkg::CNT_W'(r_below[w_cp]);
    assign w_next_alive = (w_cnt == golge_pkg::BIRTH_COUNT)
                       || (r_mid[r_col] && (w_cnt == golge_pkg::KEEP_COUNT));

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (((w_in_func == golge_pkg::FUNC_READ)
                            || (w_in_func == golge_pkg::FUNC_TOGGLE)) && !w_in_oor) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_in_row[RW-1:0];
                    end else if (w_in_func == golge_pkg::FUNC_STEP) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                    end
                end
            end
            S_CELL: begin
                if (r_func == golge_pkg::FUNC_TOGGLE) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_row;
                    w_wr_data = w_rd_row ^ (GRID_WIDTH'(1) << r_col);
                end
            end
            S_ST_L0: begin
                w_rd_en   = 1'b1;
                w_rd_addr = RW'(1);
            end
            S_ST_L1: begin
                w_rd_en   = 1'b1;
                w_rd_addr = RW'(2);
            end
            S_ST_L2: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
            end
            S_ST_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_row;
                w_wr_data = r_nrow;
                if (r_row != RW'(GRID_HEIGHT - 2)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_row + RW'(2);
                end
            end
            S_ST_LAST: begin
                w_wr_en   = 1'b1;
                w_wr_addr = RW'(GRID_HEIGHT - 1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr_en) begin
                r_row_valid[w_wr_addr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_ok <= r_row_valid[w_rd_addr];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func      <= w_in_func;
                        r_res_kind  <= w_in_func;
                        r_res_alive <= 1'b0;
                        r_res_oor   <= w_in_oor && ((w_in_func == golge_pkg::FUNC_READ)
                                           || (w_in_func == golge_pkg::FUNC_TOGGLE));
                        r_col       <= w_in_col[CW-1:0];
                        r_row       <= w_in_row[RW-1:0];
                        if ((w_in_func == golge_pkg::FUNC_READ)
                                || (w_in_func == golge_pkg::FUNC_TOGGLE)) begin
                            if (w_in_oor) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_CELL;
                            end
                        end else if (w_in_func == golge_pkg::FUNC_STEP) begin
                            r_state <= S_ST_L0;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_CELL: begin
                    r_res_alive <= w_cell_new;
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_res_kind;
                        r_out_alive <= r_res_alive;
                        r_out_oor   <= r_res_oor;
                        r_state     <= S_IDLE;
                    end
                end
                S_ST_L0: begin
                    r_above <= w_rd_row;
                    r_state <= S_ST_L1;
                end
                S_ST_L1: begin
                    r_mid   <= w_rd_row;
                    r_state <= S_ST_L2;
                end
                S_ST_L2: begin
                    r_below <= w_rd_row;
                    r_row   <= RW'(1);
                    r_col   <= CW'(1);
                    r_nrow  <= '0;
                    r_state <= S_ST_COL;
                end
                S_ST_COL: begin
                    r_nrow[r_col] <= w_next_alive;
                    if (r_col == CW'(GRID_WIDTH - 2)) begin
                        r_state <= S_ST_WR;
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                S_ST_WR: begin
                    if (r_row == RW'(GRID_HEIGHT - 2)) begin
                        r_state <= S_ST_LAST;
                    end else begin
                        r_above <= r_mid;
                        r_mid   <= r_below;
                        r_state <= S_ST_NXT;
                    end
                end
                S_ST_NXT: begin
                    r_below <= w_rd_row;
                    r_row   <= r_row + RW'(1);
                    r_col   <= CW'(1);
                    r_nrow  <= '0;
                    r_state <= S_ST_COL;
                end
                S_ST_LAST: begin
                    r_state <= S_FIN;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/golge_checker.sv =====
// Port-level checker for the grid engine, bound to the top level.
// Depends on golge_pkg for operation codes.
`default_nettype none

module golge_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [15:0] i_s_axis_tdata,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [7:0]  o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    // A held result keeps its payload until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Ready is low in the cycle after every accepted item.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready right after an accepted item");

    // An out-of-range answer belongs to a cell operation and reports a dead cell.
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |->
            !o_m_axis_tdata[0] && ((o_m_axis_tuser == golge_pkg::FUNC_READ)
                || (o_m_axis_tuser == golge_pkg::FUNC_TOGGLE)))
        else $error("bad out-of-range result");

    // A generation step answers with both flags clear.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == golge_pkg::FUNC_STEP) |->
            (o_m_axis_tdata[1:0] == 2'b00))
        else $error("step result with flags set");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind game_of_life_grid_engine golge_checker u_golge_checker (.*);

`default_nettype wire
